### sv/womt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// womt_pkg
// Shared constants and types for the observation merge table.
// ----------------------------------------------------------------------------
package womt_pkg;
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned MAX_NAME_LEN  = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_REJECTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_APPENDED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WRITE,
    FSM_OUT
  } fsm_t;

  // One table entry as it travels through the cell chain.
  typedef struct packed {
    logic [47:0] key;
    logic [7:0]  signal;
    logic [7:0]  chan;
    logic [7:0]  role;
    logic [31:0] chan_map;
    logic [31:0] last_seen;
    logic [31:0] first_seen;
    logic [15:0] count;
    logic        present;
    logic        hidden;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic rotate;
    logic wr_en;
    logic merge;
  } cell_ctl_t;
endpackage

### sv/womt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// womt_cell
// One table slot; passes its entry on to the cell below it (toward cell 0) or takes a write.
// ----------------------------------------------------------------------------
module womt_cell (
  input  logic              clk,
  input  womt_pkg::cell_ctl_t ctl,
  input  womt_pkg::entry_t  prev_entry,
  input  womt_pkg::entry_t  obs,
  output womt_pkg::entry_t  entry
);
  import womt_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rotate) begin
      entry_nxt = prev_entry;
    end else if (ctl.wr_en && !ctl.merge) begin
      entry_nxt = obs;
    end else if (ctl.wr_en) begin
      // merge the observation into the held entry
      entry_nxt.signal   = obs.signal;
      entry_nxt.chan     = obs.chan;
      entry_nxt.role     = entry_r.role | obs.role;
      entry_nxt.chan_map = entry_r.chan_map | obs.chan_map;
      if (obs.last_seen > entry_r.last_seen) entry_nxt.last_seen = obs.last_seen;
      if (obs.first_seen != 32'd0 &&
          (entry_r.first_seen == 32'd0 || obs.first_seen < entry_r.first_seen)) begin
        entry_nxt.first_seen = obs.first_seen;
      end
      if (obs.count > entry_r.count) entry_nxt.count = obs.count;
      if (obs.present && !entry_r.present) begin
        entry_nxt.present = 1'b1;
        entry_nxt.hidden  = obs.hidden;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
endmodule

### sv/wifi_observation_merge_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_observation_merge_table
// Keyed table of access point observations with oldest-entry replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one observation or clear command per transfer.
//   Result channel (out_*): exactly one result per input transfer, in order.
//   The table is a ring of TABLE_ENTRIES cells. For an ingest, the ring
//   rotates one full turn; each entry passes cell 0, the compare point,
//   in turn, one entry per cycle, so the key match (first valid hit) and
//   the oldest last-seen (first minimum) are found in that one pass. The
//   addressed cell is then written in place, and the result is registered.
//   An ingest goes from the scan state to the write and output states; a
//   clear or rejected item goes straight to the write state. in_ready
//   returns the cycle after the result transfer. One item is in work at a
//   time; the rotation loop sets the rate.
//   Reset clears the entry count, both counters and the sequencer; entry
//   contents need no clearing since only entries below the count are read.
//   When the receiver stalls, the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module wifi_observation_merge_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [47:0] in_station_address,
  input  logic signed [7:0] in_signal_level,
  input  logic [7:0]  in_radio_channel,
  input  logic [7:0]  in_role_bits,
  input  logic [31:0] in_channel_map,
  input  logic [31:0] in_last_seen,
  input  logic [31:0] in_first_seen,
  input  logic [15:0] in_sighting_count,
  input  logic        in_name_present,
  input  logic        in_name_hidden,
  input  logic [7:0]  in_name_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot,
  output logic        out_take_ssid,
  output logic [5:0]  out_entry_count,
  output logic [31:0] out_malformed_total,
  output logic [31:0] out_eviction_total
);
  import womt_pkg::*;

  fsm_t             state_r, state_nxt;
  entry_t           obs_r, obs_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;       // index of the entry now in cell 0
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [31:0]      old_ls_r, old_ls_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      mal_r, mal_nxt;
  logic [31:0]      evict_r, evict_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             take_r, take_nxt;
  logic             oval_r, oval_nxt;

  entry_t           cell_q [TABLE_ENTRIES];
  cell_ctl_t        ctl    [TABLE_ENTRIES];
  logic             present_at_slot;
  entry_t           obs_in;

  assign obs_in = '{key: in_station_address, signal: in_signal_level,
                    chan: in_radio_channel, role: in_role_bits,
                    chan_map: in_channel_map, last_seen: in_last_seen,
                    first_seen: in_first_seen, count: in_sighting_count,
                    present: in_name_present, hidden: in_name_hidden};

  // Ring of cells; after a full turn every entry is back at its own slot.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    womt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .prev_entry (cell_q[(g + 1) % TABLE_ENTRIES]),
      .obs        (obs_r),
      .entry      (cell_q[g])
    );
    always_comb begin
      ctl[g].rotate = (state_r == FSM_SCAN);
      ctl[g].wr_en  = (state_r == FSM_WRITE) && (slot_r == IDX_W'(g)) &&
                      (status_r != ST_REJECTED) && (status_r != ST_CLEARED);
      ctl[g].merge  = (status_r == ST_MERGED);
    end
  end

  assign present_at_slot = cell_q[slot_r].present;
  assign in_ready = (state_r == FSM_IDLE);

  always_comb begin
    state_nxt   = state_r;
    obs_nxt     = obs_r;
    pos_nxt     = pos_r;
    steps_nxt   = steps_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    old_idx_nxt = old_idx_r;
    old_ls_nxt  = old_ls_r;
    count_nxt   = count_r;
    mal_nxt     = mal_r;
    evict_nxt   = evict_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    take_nxt    = take_r;
    oval_nxt    = oval_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          obs_nxt   = obs_in;
          pos_nxt   = '0;
          steps_nxt = '0;
          hit_nxt   = 1'b0;
          old_idx_nxt = '0;
          slot_nxt  = '0;
          take_nxt  = 1'b0;
          if (in_kind) begin
            count_nxt  = '0;
            mal_nxt    = '0;
            evict_nxt  = '0;
            status_nxt = ST_CLEARED;
            state_nxt  = FSM_WRITE;
          end else if (in_name_length > 8'(MAX_NAME_LEN)) begin
            if (mal_r != 32'hFFFF_FFFF) mal_nxt = mal_r + 32'd1;
            status_nxt = ST_REJECTED;
            state_nxt  = FSM_WRITE;
          end else begin
            state_nxt = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        // compare the entry sitting in cell 0, then advance the ring
        if (!hit_r && (CNT_W'(pos_r) < count_r) && cell_q[0].key == obs_r.key) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pos_r;
        end
        if (pos_r == '0 || cell_q[0].last_seen < old_ls_r) begin
          old_idx_nxt = pos_r;
          old_ls_nxt  = cell_q[0].last_seen;
        end
        pos_nxt   = pos_r + IDX_W'(1);
        steps_nxt = steps_r + CNT_W'(1);
        if (steps_r == CNT_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = FSM_WRITE;
          take_nxt  = 1'b1;
          if (hit_nxt) begin
            status_nxt = ST_MERGED;
            slot_nxt   = hit_idx_nxt;
          end else if (count_r == CNT_W'(TABLE_ENTRIES)) begin
            status_nxt = ST_REPLACED;
            slot_nxt   = old_idx_nxt;
            if (evict_r != 32'hFFFF_FFFF) evict_nxt = evict_r + 32'd1;
          end else begin
            status_nxt = ST_APPENDED;
            slot_nxt   = IDX_W'(count_r);
            count_nxt  = count_r + CNT_W'(1);
          end
        end
      end
      FSM_WRITE: begin
        if (status_r == ST_MERGED) take_nxt = obs_r.present && !present_at_slot;
        oval_nxt  = 1'b1;
        state_nxt = FSM_OUT;
      end
      FSM_OUT: begin
        if (out_ready) begin
          oval_nxt  = 1'b0;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      count_r <= '0;
      mal_r   <= '0;
      evict_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mal_r   <= mal_nxt;
      evict_r <= evict_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obs_r     <= obs_nxt;
    pos_r     <= pos_nxt;
    steps_r   <= steps_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    old_idx_r <= old_idx_nxt;
    old_ls_r  <= old_ls_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    take_r    <= take_nxt;
  end

  assign out_valid           = oval_r;
  assign out_status          = status_r;
  assign out_slot            = 5'(slot_r);
  assign out_take_ssid       = take_r;
  assign out_entry_count     = 6'(count_r);
  assign out_malformed_total = mal_r;
  assign out_eviction_total  = evict_r;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot))
    else $error("result dropped while stalled");
`endif
endmodule

### tb/sv/wifi_observation_merge_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_observation_merge_table_tb
// Self-checking bench for the observation merge table.
// ----------------------------------------------------------------------------
// A queue of observations and clear commands feeds a clocked driver. A clocked
// monitor runs the table predictor on every accepted input transfer and checks
// each result transfer against the oldest queued expectation. Random traffic
// draws most addresses from a small pool so that merges, appends and, once the
// table is full, oldest-entry replacement all occur. Idle phases vary the sender and
// receiver duty, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module wifi_observation_merge_table_tb;
  import womt_pkg::*;

  typedef struct {
    logic        kind;
    logic [47:0] addr;
    logic [7:0]  sig;
    logic [7:0]  chan;
    logic [7:0]  role;
    logic [31:0] cmap;
    logic [31:0] last;
    logic [31:0] first;
    logic [15:0] cnt;
    logic        present;
    logic        hidden;
    logic [7:0]  nlen;
  } obs_t;

  typedef struct {
    status_t     status;
    logic [4:0]  slot;
    logic        take;
    logic [5:0]  entries;
    logic [31:0] malformed;
    logic [31:0] evictions;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [47:0] in_station_address = '0;
  logic signed [7:0] in_signal_level = '0;
  logic [7:0] in_radio_channel = '0;
  logic [7:0] in_role_bits = '0;
  logic [31:0] in_channel_map = '0;
  logic [31:0] in_last_seen = '0;
  logic [31:0] in_first_seen = '0;
  logic [15:0] in_sighting_count = '0;
  logic in_name_present = 1'b0;
  logic in_name_hidden = 1'b0;
  logic [7:0] in_name_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [4:0] out_slot;
  logic out_take_ssid;
  logic [5:0] out_entry_count;
  logic [31:0] out_malformed_total;
  logic [31:0] out_eviction_total;

  wifi_observation_merge_table dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor's copy of the table.
  obs_t        tbl [TABLE_ENTRIES];
  int unsigned tbl_fill;
  logic [31:0] malformed_cnt;
  logic [31:0] evict_cnt;

  obs_t     pending_obs[$];
  verdict_t expected_results[$];
  int unsigned errors = 0;
  int unsigned n_merge = 0, n_append = 0, n_replace = 0, n_reject = 0, n_clear = 0;
  int unsigned sent = 0, checked = 0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;

  function automatic verdict_t merge_table_step(obs_t o);
    verdict_t    r;
    int          hit;
    int unsigned s;
    r.slot = '0;
    r.take = 1'b0;
    if (o.kind) begin
      tbl_fill = 0;
      malformed_cnt = '0;
      evict_cnt = '0;
      r.status = ST_CLEARED;
    end else if (o.nlen > MAX_NAME_LEN) begin
      if (malformed_cnt != 32'hFFFF_FFFF) malformed_cnt++;
      r.status = ST_REJECTED;
    end else begin
      hit = -1;
      for (int i = 0; i < tbl_fill; i++)
        if (hit < 0 && tbl[i].addr == o.addr) hit = i;
      if (hit >= 0) begin
        s = hit;
        tbl[s].sig = o.sig;
        tbl[s].chan = o.chan;
        tbl[s].role |= o.role;
        tbl[s].cmap |= o.cmap;
        if (o.last > tbl[s].last) tbl[s].last = o.last;
        if (o.first != 0 && (tbl[s].first == 0 || o.first < tbl[s].first))
          tbl[s].first = o.first;
        if (o.cnt > tbl[s].cnt) tbl[s].cnt = o.cnt;
        if (o.present && !tbl[s].present) begin
          tbl[s].present = 1'b1;
          tbl[s].hidden = o.hidden;
          r.take = 1'b1;
        end
        r.status = ST_MERGED;
      end else if (tbl_fill >= TABLE_ENTRIES) begin
        s = 0;
        for (int i = 1; i < TABLE_ENTRIES; i++)
          if (tbl[i].last < tbl[s].last) s = i;
        tbl[s] = o;
        r.take = 1'b1;
        if (evict_cnt != 32'hFFFF_FFFF) evict_cnt++;
        r.status = ST_REPLACED;
      end else begin
        s = tbl_fill;
        tbl[s] = o;
        tbl_fill++;
        r.take = 1'b1;
        r.status = ST_APPENDED;
      end
      r.slot = s[4:0];
    end
    r.entries = tbl_fill[5:0];
    r.malformed = malformed_cnt;
    r.evictions = evict_cnt;
    return r;
  endfunction

  // Driver: offer the head of the queue, hold it until the transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) void'(pending_obs.pop_front());
        if (pending_obs.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          obs_t o;
          o = pending_obs[0];
          in_valid <= 1'b1;
          in_kind <= o.kind;
          in_station_address <= o.addr;
          in_signal_level <= o.sig;
          in_radio_channel <= o.chan;
          in_role_bits <= o.role;
          in_channel_map <= o.cmap;
          in_last_seen <= o.last;
          in_first_seen <= o.first;
          in_sighting_count <= o.cnt;
          in_name_present <= o.present;
          in_name_hidden <= o.hidden;
          in_name_length <= o.nlen;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input transfers, check on result transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        obs_t o;
        o.kind = in_kind; o.addr = in_station_address; o.sig = in_signal_level;
        o.chan = in_radio_channel; o.role = in_role_bits; o.cmap = in_channel_map;
        o.last = in_last_seen; o.first = in_first_seen; o.cnt = in_sighting_count;
        o.present = in_name_present; o.hidden = in_name_hidden;
        o.nlen = in_name_length;
        expected_results.push_back(merge_table_step(o));
        sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors++;
        end else begin
          verdict_t e;
          e = expected_results.pop_front();
          checked++;
          case (e.status)
            ST_MERGED:   n_merge++;
            ST_APPENDED: n_append++;
            ST_REPLACED: n_replace++;
            ST_REJECTED: n_reject++;
            default:     n_clear++;
          endcase
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status); errors++;
          end
          if (out_slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, out_slot); errors++;
          end
          if (out_take_ssid !== e.take) begin
            $error("take_ssid: expected %0d, got %0d", e.take, out_take_ssid); errors++;
          end
          if (out_entry_count !== e.entries) begin
            $error("entry_count: expected %0d, got %0d", e.entries, out_entry_count);
            errors++;
          end
          if (out_malformed_total !== e.malformed) begin
            $error("malformed_total: expected %0d, got %0d", e.malformed,
                   out_malformed_total);
            errors++;
          end
          if (out_eviction_total !== e.evictions) begin
            $error("eviction_total: expected %0d, got %0d", e.evictions,
                   out_eviction_total);
            errors++;
          end
        end
      end
    end
  end

  logic [47:0] addr_pool [48];

  function automatic obs_t rand_obs();
    obs_t o;
    int   k;
    o.kind = 1'b0;
    k = $urandom_range(99);
    // Mostly pooled addresses so entries get hit again; sometimes fresh ones.
    o.addr = (k < 85) ? addr_pool[$urandom_range(47)] : 48'({$urandom, $urandom});
    o.sig = 8'($urandom); o.chan = 8'($urandom); o.role = 8'($urandom);
    o.cmap = $urandom;
    o.last = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    o.first = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    o.cnt = 16'($urandom);
    o.present = 1'($urandom); o.hidden = 1'($urandom);
    k = $urandom_range(99);
    o.nlen = (k < 8) ? 8'($urandom_range(255, MAX_NAME_LEN + 1)) :
             (k < 12) ? 8'(MAX_NAME_LEN) : 8'($urandom_range(MAX_NAME_LEN));
    return o;
  endfunction

  task automatic queue_obs(obs_t o);
    pending_obs.push_back(o);
  endtask

  // Check on the falling edge, when every rising-edge update has settled.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_obs.size() != 0 || expected_results.size() != 0);
  endtask

  initial begin
    obs_t o;
    for (int i = 0; i < 48; i++) addr_pool[i] = 48'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    tbl_fill = 0; malformed_cnt = '0; evict_cnt = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, merges, accept at and reject past the name limit, clear.
    o = '{1'b0, 48'h0, 8'h80, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0,
          1'b0, 1'b0, 8'd0};
    queue_obs(o);
    o = '{1'b0, '1, 8'h7F, 8'hFF, 8'hFF, '1, '1, '1, '1, 1'b1, 1'b1, 8'd32};
    queue_obs(o);
    // Merge into the unnamed entry: takes name, raises first_seen from zero.
    o = '{1'b0, 48'h0, 8'h01, 8'h06, 8'h0A, 32'h5, 32'h10, 32'h7, 16'h3,
          1'b1, 1'b0, 8'd5};
    queue_obs(o);
    // Merge again: name already held, higher stored last/count kept, earlier first wins.
    o = '{1'b0, 48'h0, 8'hF0, 8'h0B, 8'h50, 32'hA0, 32'h4, 32'h2, 16'h1,
          1'b1, 1'b1, 8'd3};
    queue_obs(o);
    o.first = 32'd0; queue_obs(o);
    o.nlen = 8'd33; queue_obs(o);
    o.nlen = 8'd255; queue_obs(o);
    o = '{1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, 8'd0};
    queue_obs(o);
    // Overfill: slot 7 (oldest) goes first, then tied last_seen picks lowest index.
    for (int i = 0; i < TABLE_ENTRIES + 3; i++) begin
      o = rand_obs();
      o.addr = 48'(i + 100);
      o.last = (i == 7) ? 32'd1 : 32'd9;
      o.nlen = 8'd1;
      queue_obs(o);
    end
    drain();

    // Random phases: none, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 36 : 71) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 36 : 71) : 0;
      for (int n = 0; n < 260; n++) begin
        if ($urandom_range(99) < 2) begin
          o = rand_obs(); o.kind = 1'b1; queue_obs(o);
        end else begin
          queue_obs(rand_obs());
        end
      end
      if (ph == 0) begin
        // Hold the receiver off while the sender keeps offering.
        wait (pending_obs.size() < 240);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    repeat (50) @(posedge clk);
    $display("Checked %0d of %0d items: %0d merged, %0d appended, %0d replaced,",
             checked, sent, n_merge, n_append, n_replace);
    $display("  %0d rejected, %0d cleared, across four idle phases and a hold-off.",
             n_reject, n_clear);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### files.f
sv/womt_pkg.sv
sv/womt_cell.sv
sv/wifi_observation_merge_table.sv
tb/sv/wifi_observation_merge_table_tb.sv
